### sv/fraction_reducer_top_assert.svh
// ----------------------------------------------------------------------------
// fraction_reducer_top_assert.svh
// Assertion macros for the fraction reducer checker.
// ----------------------------------------------------------------------------
`ifndef FRACTION_REDUCER_TOP_ASSERT_SVH
`define FRACTION_REDUCER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define FRT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define FRT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/frac_pkg.sv
// ----------------------------------------------------------------------------
// frac_pkg
// Types and constants shared by the fraction reducer modules.
// ----------------------------------------------------------------------------
package frac_pkg;

   localparam int WORD_BITS = 32;
   localparam int CNT_BITS  = $clog2(WORD_BITS);

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [1:0] ST_RANGE    = 2'd2;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] top_value;
      logic signed [WORD_BITS-1:0] bottom_value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] reduced_top;
      logic        [WORD_BITS-2:0] reduced_bottom;
      logic        [1:0]           status;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic gcd_step;
      logic div_load;
      logic div_sel_den;
      logic div_step;
      logic out_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic special;
      logic gcd_done;
      logic div_last;
   } stat_type;

endpackage

### sv/frac_ctrl.sv
// ----------------------------------------------------------------------------
// frac_ctrl
// Sequencer: load, binary GCD, two restoring divisions, result hand-off.
// ----------------------------------------------------------------------------
module frac_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output frac_pkg::cmd_type  cmd,
   input  frac_pkg::stat_type stat
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_GCD,
      S_DIV_N,
      S_DIV_D,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            priority if (stat.special) begin
               state_in = S_FINISH;
            end else if (stat.gcd_done) begin
               cmd.div_load = 1'b1;
               state_in     = S_DIV_N;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_DIV_N: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               cmd.div_load    = 1'b1;
               cmd.div_sel_den = 1'b1;
               state_in        = S_DIV_D;
            end
         end
         S_DIV_D: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### sv/frac_dp.sv
// ----------------------------------------------------------------------------
// frac_dp
// Datapath: magnitudes, binary GCD, shared restoring divider, output register.
// ----------------------------------------------------------------------------
module frac_dp (
   input  logic               clock,
   input  frac_pkg::req_type  req_data,
   input  frac_pkg::cmd_type  cmd,
   output frac_pkg::stat_type stat,
   output frac_pkg::rsp_type  rsp_data
);

   localparam int W = frac_pkg::WORD_BITS;
   localparam int C = frac_pkg::CNT_BITS;
   localparam logic [C-1:0] CNT_LAST = C'(W - 1);

   logic [W-1:0] a_ff, a_in, b_ff, b_in;
   logic [C-1:0] k_ff, k_in;
   logic [W-1:0] mag_n_ff, mag_n_in, mag_d_ff, mag_d_in;
   logic         neg_ff, neg_in, zero_den_ff, zero_den_in, zero_num_ff, zero_num_in;
   logic [W-1:0] g_ff, g_in, rem_ff, rem_in, dvd_ff, dvd_in, quo_ff, quo_in;
   logic [C-1:0] cnt_ff, cnt_in;
   logic         phase_ff, phase_in;
   logic [W-1:0] rn_ff, rn_in, rd_ff, rd_in;
   frac_pkg::rsp_type rsp_ff, rsp_in, result;

   logic [W-1:0] req_top, req_bot, mag_top, mag_bot;
   logic [W:0]   shifted, diff;
   logic         fits;
   logic [W-1:0] quo_next, rem_next;
   logic         range_err;

   assign req_top = req_data.top_value;
   assign req_bot = req_data.bottom_value;
   assign mag_top = req_top[W-1] ? (~req_top + W'(1)) : req_top;
   assign mag_bot = req_bot[W-1] ? (~req_bot + W'(1)) : req_bot;

   // one restoring division step
   assign shifted  = {rem_ff, dvd_ff[W-1]};
   assign diff     = shifted - {1'b0, g_ff};
   assign fits     = (shifted >= {1'b0, g_ff});
   assign rem_next = fits ? diff[W-1:0] : shifted[W-1:0];
   assign quo_next = {quo_ff[W-2:0], fits};

   assign stat.special  = zero_den_ff | zero_num_ff;
   assign stat.gcd_done = (a_ff == b_ff);
   assign stat.div_last = (cnt_ff == CNT_LAST);

   always_comb begin
      a_in        = a_ff;
      b_in        = b_ff;
      k_in        = k_ff;
      mag_n_in    = mag_n_ff;
      mag_d_in    = mag_d_ff;
      neg_in      = neg_ff;
      zero_den_in = zero_den_ff;
      zero_num_in = zero_num_ff;
      g_in        = g_ff;
      rem_in      = rem_ff;
      dvd_in      = dvd_ff;
      quo_in      = quo_ff;
      cnt_in      = cnt_ff;
      phase_in    = phase_ff;
      rn_in       = rn_ff;
      rd_in       = rd_ff;

      if (cmd.load) begin
         a_in        = mag_top;
         b_in        = mag_bot;
         k_in        = '0;
         mag_n_in    = mag_top;
         mag_d_in    = mag_bot;
         neg_in      = req_top[W-1] ^ req_bot[W-1];
         zero_den_in = (mag_bot == '0);
         zero_num_in = (mag_top == '0);
      end

      if (cmd.gcd_step) begin
         priority if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + C'(1);
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff > b_ff) begin
            a_in = (a_ff - b_ff) >> 1;
         end else begin
            b_in = (b_ff - a_ff) >> 1;
         end
      end

      if (cmd.div_step) begin
         rem_in = rem_next;
         dvd_in = {dvd_ff[W-2:0], 1'b0};
         quo_in = quo_next;
         cnt_in = cnt_ff + C'(1);
         if (cnt_ff == CNT_LAST) begin
            if (phase_ff) begin
               rd_in = quo_next;
            end else begin
               rn_in = quo_next;
            end
         end
      end

      // a load on the last step of the first division takes over the working regs
      if (cmd.div_load) begin
         g_in     = a_ff << k_ff;
         rem_in   = '0;
         dvd_in   = cmd.div_sel_den ? mag_d_ff : mag_n_ff;
         quo_in   = '0;
         cnt_in   = '0;
         phase_in = cmd.div_sel_den;
      end
   end

   assign range_err = rd_ff[W-1]
                    | (!neg_ff && rn_ff[W-1])
                    | (neg_ff && rn_ff[W-1] && (rn_ff[W-2:0] != '0));

   always_comb begin
      priority if (zero_den_ff) begin
         result.reduced_top    = '0;
         result.reduced_bottom = '0;
         result.status         = frac_pkg::ST_ZERO_DEN;
      end else if (zero_num_ff) begin
         result.reduced_top    = '0;
         result.reduced_bottom = (W-1)'(1);
         result.status         = frac_pkg::ST_OK;
      end else if (range_err) begin
         result.reduced_top    = '0;
         result.reduced_bottom = '0;
         result.status         = frac_pkg::ST_RANGE;
      end else begin
         result.reduced_top    = neg_ff ? (~rn_ff + W'(1)) : rn_ff;
         result.reduced_bottom = rd_ff[W-2:0];
         result.status         = frac_pkg::ST_OK;
      end
   end

   assign rsp_in = cmd.out_load ? result : rsp_ff;

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      k_ff        <= k_in;
      mag_n_ff    <= mag_n_in;
      mag_d_ff    <= mag_d_in;
      neg_ff      <= neg_in;
      zero_den_ff <= zero_den_in;
      zero_num_ff <= zero_num_in;
      g_ff        <= g_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      phase_ff    <= phase_in;
      rn_ff       <= rn_in;
      rd_ff       <= rd_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

### sv/fraction_reducer_top.sv
// ----------------------------------------------------------------------------
// fraction_reducer_top
// Reduces a signed fraction to lowest terms with a positive denominator.
//
//   channel | ports                        | payload
//   --------+------------------------------+--------------------
//   input   | req_valid, req_stall         | req_data (req_type)
//   result  | rsp_valid, rsp_stall         | rsp_data (rsp_type)
//
// One item at a time: a load, binary GCD steps until the two values match, then
// two restoring divisions (numerator, then denominator) on one shared divider,
// then the output register; a zero numerator or denominator skips the GCD and
// the divisions. A finished item waits while the output stalls.
// Synchronous active-high reset clears the sequencer and the output valid.
// A new item is taken while the previous result is still stalled at the output.
// ----------------------------------------------------------------------------
module fraction_reducer_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  frac_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output frac_pkg::rsp_type rsp_data
);

   frac_pkg::cmd_type  cmd;
   frac_pkg::stat_type stat;

   frac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   frac_dp u_dp (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

### sv/frac_checker.sv
// ----------------------------------------------------------------------------
// frac_checker
// Port-level checks on the fraction reducer, bound to the top level.
// ----------------------------------------------------------------------------
`include "fraction_reducer_top_assert.svh"

module frac_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input frac_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input frac_pkg::rsp_type rsp_data
);

   // a stalled result stays put
   `FRT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "rsp changed while stalled")

   `FRT_ASSERT_NOW(a_zero_den, rsp_valid && rsp_data.status == frac_pkg::ST_ZERO_DEN, rsp_data.reduced_top == '0 && rsp_data.reduced_bottom == '0, "zero denominator result not cleared")

   `FRT_ASSERT_NOW(a_range, rsp_valid && rsp_data.status == frac_pkg::ST_RANGE, rsp_data.reduced_top == '0 && rsp_data.reduced_bottom == '0, "range error result not cleared")

   // a good result always has a positive denominator
   `FRT_ASSERT_NOW(a_ok_den, rsp_valid && rsp_data.status == frac_pkg::ST_OK, rsp_data.reduced_bottom != '0, "ok result with zero denominator")

endmodule

bind fraction_reducer_top frac_checker u_checker (.*);

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks fraction_reducer_top: a short table of hand-picked fractions (zero
// and extreme operands, sign combinations, out-of-range results), then
// random fractions with shared factors, powers of two and full-width words.
// Every result is compared field by field against a typed value or a software reduction.
// ----------------------------------------------------------------------------
module testbench;
   import frac_pkg::*;

   localparam int WB = WORD_BITS;
   localparam logic signed [WB-1:0] MOST_NEG = {1'b1, {(WB-1){1'b0}}};
   localparam logic signed [WB-1:0] MOST_POS = ~MOST_NEG;
   localparam int RANDOM_ITEMS = 1625;
   localparam int IDLE_PCT     = 19;
   localparam int QUIET_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 300;

   typedef struct {
      req_type item;
      rsp_type want;
   } pending_fraction;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } table_row;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   bit              calm_stretch = 1'b0;
   int unsigned     error_count  = 0;
   pending_fraction expected_fractions[$];
   table_row        directed_rows[$];

   fraction_reducer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] word_magnitude(input logic signed [WB-1:0] w);
      logic signed [63:0] wide;
      wide = w;
      return (wide < 0) ? -wide : wide;
   endfunction

   // exact reduction on 64-bit magnitudes, then range check against the fields
   function automatic rsp_type reduce_fraction(input req_type r);
      logic [63:0] num_mag, den_mag, a, b, t, rn, rd, half;
      logic        flip;
      rsp_type     res;
      res = '0;
      res.status = ST_OK;
      half = 64'd1 << (WB - 1);
      num_mag = word_magnitude(r.top_value);
      den_mag = word_magnitude(r.bottom_value);
      flip = r.top_value[WB-1] ^ r.bottom_value[WB-1];
      if (den_mag == 0) begin
         res.status = ST_ZERO_DEN;
      end else if (num_mag == 0) begin
         res.reduced_bottom = 1;
      end else begin
         a = num_mag;
         b = den_mag;
         while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
         end
         rn = num_mag / a;
         rd = den_mag / a;
         if (rd >= half || (!flip && rn >= half) || (flip && rn > half)) begin
            res.status = ST_RANGE;
         end else begin
            res.reduced_top    = flip ? -rn[WB-1:0] : rn[WB-1:0];
            res.reduced_bottom = rd[WB-2:0];
         end
      end
      return res;
   endfunction

   function automatic logic signed [WB-1:0] edge_word();
      case ($urandom_range(8))
         0: return MOST_NEG;
         1: return MOST_NEG + 1;
         2: return MOST_POS;
         3: return MOST_POS - 1;
         4: return 0;
         5: return 1;
         6: return -1;
         7: return MOST_NEG >>> 1;
         default: return -(MOST_NEG >>> 1);
      endcase
   endfunction

   function automatic req_type random_fraction();
      req_type     r;
      int unsigned pick, k;
      pick = $urandom_range(99);
      if (pick < 30) begin
         r.top_value    = $urandom;
         r.bottom_value = $urandom;
      end else if (pick < 50) begin
         r.top_value    = $signed($urandom_range(400)) - 200;
         r.bottom_value = $signed($urandom_range(400)) - 200;
      end else if (pick < 78) begin
         // shared factor so the divider path does real work
         k = $urandom_range(65535, 1);
         r.top_value    = $urandom_range(32767) * k;
         r.bottom_value = $urandom_range(32767, 1) * k;
         if ($urandom_range(1)) r.top_value = -r.top_value;
         if ($urandom_range(1)) r.bottom_value = -r.bottom_value;
      end else if (pick < 90) begin
         r.top_value    = MOST_NEG >>> (WB - 1 - $urandom_range(WB - 1));
         r.bottom_value = MOST_NEG >>> (WB - 1 - $urandom_range(WB - 1));
         if ($urandom_range(1)) r.top_value = -r.top_value;
         if ($urandom_range(1)) r.bottom_value = -r.bottom_value;
         r.top_value[WB-1:WB-2]    = r.top_value[WB-1:WB-2];
      end else begin
         r.top_value    = edge_word();
         r.bottom_value = $urandom_range(1) ? edge_word() : $signed($urandom);
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic add_row(input logic signed [WB-1:0] top_in, bottom_in, input bit typed,
                          input logic signed [WB-1:0] want_top,
                          input logic [WB-2:0] want_bottom, input logic [1:0] want_status);
      table_row row;
      row.item.top_value       = top_in;
      row.item.bottom_value    = bottom_in;
      row.typed                = typed;
      row.want.reduced_top     = want_top;
      row.want.reduced_bottom  = want_bottom;
      row.want.status          = want_status;
      directed_rows.push_back(row);
   endtask

   // present one fraction, wait for the transfer, then queue what it should give
   task automatic send_fraction(input req_type item, input rsp_type want);
      pending_fraction p;
      while (!calm_stretch && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p.item = item;
      p.want = want;
      expected_fractions.push_back(p);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !calm_stretch && ($urandom_range(99) < IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      pending_fraction p;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_fractions.size() == 0) begin
            report_mismatch($sformatf("unexpected result %0d/%0d status %0d",
                            rsp_data.reduced_top, rsp_data.reduced_bottom, rsp_data.status));
         end else begin
            p = expected_fractions.pop_front();
            if (rsp_data.status !== p.want.status)
               report_mismatch($sformatf("%0d/%0d: status %0d, want %0d",
                               p.item.top_value, p.item.bottom_value,
                               rsp_data.status, p.want.status));
            if (rsp_data.reduced_top !== p.want.reduced_top)
               report_mismatch($sformatf("%0d/%0d: top %0d, want %0d",
                               p.item.top_value, p.item.bottom_value,
                               rsp_data.reduced_top, p.want.reduced_top));
            if (rsp_data.reduced_bottom !== p.want.reduced_bottom)
               report_mismatch($sformatf("%0d/%0d: bottom %0d, want %0d",
                               p.item.top_value, p.item.bottom_value,
                               rsp_data.reduced_bottom, p.want.reduced_bottom));
         end
      end
   end

   // hang detector: cycles with no transfer on either channel
   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("** fraction_reducer_top: FAILED **");
      $finish;
   end

   initial begin
      req_type item;
      rsp_type want;

      // zero denominator
      add_row(7, 0, 1, 0, 0, ST_ZERO_DEN);
      add_row(0, 0, 1, 0, 0, ST_ZERO_DEN);
      add_row(MOST_NEG, 0, 1, 0, 0, ST_ZERO_DEN);
      add_row(MOST_POS, 0, 1, 0, 0, ST_ZERO_DEN);
      // zero numerator gives 0/1 whatever the sign below
      add_row(0, -5, 1, 0, 1, ST_OK);
      add_row(0, MOST_NEG, 1, 0, 1, ST_OK);
      add_row(0, MOST_POS, 1, 0, 1, ST_OK);
      // extremes
      add_row(MOST_NEG, MOST_NEG, 1, 1, 1, ST_OK);
      add_row(MOST_POS, MOST_POS, 1, 1, 1, ST_OK);
      add_row(MOST_NEG, 1, 1, MOST_NEG, 1, ST_OK);
      add_row(MOST_NEG, MOST_POS, 1, MOST_NEG, MOST_POS[WB-2:0], ST_OK);
      add_row(MOST_POS, -1, 1, -MOST_POS, 1, ST_OK);
      add_row(-1, -1, 1, 1, 1, ST_OK);
      // magnitude 2^(WB-1) left after reduction
      add_row(MOST_NEG, -1, 1, 0, 0, ST_RANGE);
      add_row(1, MOST_NEG, 1, 0, 0, ST_RANGE);
      add_row(-1, MOST_NEG, 1, 0, 0, ST_RANGE);
      add_row(MOST_POS, MOST_NEG, 1, 0, 0, ST_RANGE);
      // remaining rows go through the predictor
      add_row(6, -4, 0, 0, 0, ST_OK);
      add_row(-6, -4, 0, 0, 0, ST_OK);
      add_row(12, 18, 0, 0, 0, ST_OK);
      add_row(MOST_NEG, 2, 0, 0, 0, ST_OK);
      add_row(MOST_NEG, -2, 0, 0, 0, ST_OK);
      add_row(2, MOST_NEG, 0, 0, 0, ST_OK);
      add_row(MOST_NEG >>> 1, MOST_NEG, 0, 0, 0, ST_OK);
      add_row(46368, -28657, 0, 0, 0, ST_OK);
      add_row(1836311903, 1134903170, 0, 0, 0, ST_OK);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         want = directed_rows[i].typed ? directed_rows[i].want
                                       : reduce_fraction(directed_rows[i].item);
         send_fraction(directed_rows[i].item, want);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 700) calm_stretch <= 1'b1;
         if (n == 1000) calm_stretch <= 1'b0;
         item = random_fraction();
         send_fraction(item, reduce_fraction(item));
      end
      req_valid <= 1'b0;

      while (expected_fractions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_fractions.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_fractions.size()));

      if (error_count == 0)
         $display("** fraction_reducer_top: PASSED **");
      else
         $display("** fraction_reducer_top: FAILED **");
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/frac_pkg.sv
sv/frac_ctrl.sv
sv/frac_dp.sv
sv/fraction_reducer_top.sv
sv/frac_checker.sv
verif/testbench.sv
